// ----- sv/ppct_pkg.sv -----
// shared types and constants for the pedal percent normalizer
package ppct_pkg;

  localparam int unsigned CFG_W = 12;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned QUOT_W = 7;
  localparam int unsigned SHIFT_W = 3;
  localparam int unsigned IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_SPAN_THR = 2'd0;
  localparam logic [IDX_W-1:0] REG_IDLE_WIN = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEADBAND = 2'd2;
  localparam logic [IDX_W-1:0] REG_FLT_SHIFT = 2'd3;

  localparam logic [CFG_W-1:0] SPAN_THR_RST = 12'd20;
  localparam logic [CFG_W-1:0] IDLE_WIN_RST = 12'd8;
  localparam logic [PCT_W-1:0] DEADBAND_RST = 7'd2;
  localparam logic [SHIFT_W-1:0] FLT_SHIFT_RST = 3'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_FILT
  } state_e;

endpackage

// ----- sv/pedal_self_calibrating_percent.sv -----
// top level: learned min/max pedal normalizer with low-pass output
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_ready_o  | raw_sample_i
//  out     | output    | out_valid_o / out_ready_i| percent_out_o, signal_ok_o,
//          |           |                          | learned_min_o, learned_max_o
//  cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// one item at a time: after a transfer the item passes prep, divide and filter
// when the divide runs, prep and filter otherwise; the serial divider (one
// quotient bit a cycle, 7 bits) does the divide.
// a finished result sits in the output register, so the next item is taken
// while it waits; a result that finds that register still full holds the core.
// reset clears min to all ones, max, filter state and config to defaults.
module pedal_self_calibrating_percent import ppct_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] raw_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [PCT_W-1:0]       percent_out_o,
  output logic                   signal_ok_o,
  output logic [SAMPLE_BITS-1:0] learned_min_o,
  output logic [SAMPLE_BITS-1:0] learned_max_o,
  input  logic                   cfg_we_i,
  input  logic [IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned NW = SAMPLE_BITS + QUOT_W;
  localparam int unsigned CW = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 1;

  state_e state_q, state_d;

  logic [CFG_W-1:0]       span_thr_q, idle_win_q;
  logic [PCT_W-1:0]       deadband_q;
  logic [SHIFT_W-1:0]     flt_shift_q;

  logic [SAMPLE_BITS-1:0] raw_q, min_q, max_q;
  logic                   ok_q, ok_d;
  logic [PCT_W-1:0]       target_q, target_d;
  logic [PCT_W-1:0]       filt_q;
  logic                   primed_q;
  logic                   out_valid_q;
  logic [PCT_W-1:0]       pct_out_q;
  logic                   ok_out_q;
  logic [SAMPLE_BITS-1:0] min_out_q, max_out_q;

  logic                   in_xfer, out_free, load_out, div_start, div_done;
  logic [SAMPLE_BITS-1:0] span, delta;
  logic [NW-1:0]          delta_w, num;
  logic [QUOT_W-1:0]      quot;
  logic [PCT_W-1:0]       result;
  logic                   above_idle;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign span    = max_q - min_q;
  assign delta   = raw_q - min_q;
  assign delta_w = NW'(delta);
  assign num     = (delta_w << 6) + (delta_w << 5) + (delta_w << 2);
  assign above_idle = CW'(raw_q) > (CW'(min_q) + CW'(idle_win_q));

  ppct_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (span),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  ppct_iir u_iir (
    .valid_i    (ok_q),
    .primed_i   (primed_q),
    .filt_i     (filt_q),
    .target_i   (target_q),
    .deadband_i (deadband_q),
    .shift_i    (flt_shift_q),
    .result_o   (result)
  );

  always_comb begin
    state_d   = state_q;
    ok_d      = ok_q;
    target_d  = target_q;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        ok_d     = (max_q > min_q) && (CW'(span) >= CW'(span_thr_q));
        target_d = '0;
        if (ok_d && above_idle) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_FILT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          target_d = (quot > 7'd100) ? 7'd100 : quot;
          state_d  = S_FILT;
        end
      end
      S_FILT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      span_thr_q  <= SPAN_THR_RST;
      idle_win_q  <= IDLE_WIN_RST;
      deadband_q  <= DEADBAND_RST;
      flt_shift_q <= FLT_SHIFT_RST;
      min_q       <= '1;
      max_q       <= '0;
      ok_q        <= 1'b0;
      target_q    <= '0;
      filt_q      <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ok_q     <= ok_d;
      target_q <= target_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SPAN_THR:  span_thr_q  <= cfg_data_i;
          REG_IDLE_WIN:  idle_win_q  <= cfg_data_i;
          REG_DEADBAND:  deadband_q  <= cfg_data_i[PCT_W-1:0];
          REG_FLT_SHIFT: flt_shift_q <= cfg_data_i[SHIFT_W-1:0];
          default: ;
        endcase
      end
      // widen the learned range on transfer
      if (in_xfer) begin
        if (raw_sample_i < min_q) begin
          min_q <= raw_sample_i;
        end
        if (raw_sample_i > max_q) begin
          max_q <= raw_sample_i;
        end
      end
      if (load_out) begin
        filt_q      <= result;
        primed_q    <= ok_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      raw_q <= raw_sample_i;
    end
    if (load_out) begin
      pct_out_q <= result;
      ok_out_q  <= ok_q;
      min_out_q <= min_q;
      max_out_q <= max_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign percent_out_o = pct_out_q;
  assign signal_ok_o   = ok_out_q;
  assign learned_min_o = min_out_q;
  assign learned_max_o = max_out_q;

endmodule

// ----- sv/ppct_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module ppct_div import ppct_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [SAMPLE_BITS+6:0]   num_i,
  input  logic [SAMPLE_BITS-1:0]   den_i,
  output logic                     done_o,
  output logic [QUOT_W-1:0]        quot_o
);

  localparam int unsigned NW = SAMPLE_BITS + QUOT_W;

  logic [NW-1:0]     rem_q, rem_d;
  logic [NW-1:0]     dvs_q, dvs_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              ge;

  always_comb begin
    ge     = rem_q >= dvs_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      dvs_d  = {1'b0, den_i, 6'b0};
      quot_d = '0;
      cnt_d  = 3'(QUOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dvs_q;
      end
      quot_d = {quot_q[QUOT_W-2:0], ge};
      dvs_d  = dvs_q >> 1;
      cnt_d  = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- sv/ppct_iir.sv -----
// deadband hold and rounded first-order low-pass step; zero when invalid, target when not yet primed
module ppct_iir import ppct_pkg::*; (
  input  logic               valid_i,
  input  logic               primed_i,
  input  logic [PCT_W-1:0]   filt_i,
  input  logic [PCT_W-1:0]   target_i,
  input  logic [PCT_W-1:0]   deadband_i,
  input  logic [SHIFT_W-1:0] shift_i,
  output logic [PCT_W-1:0]   result_o
);

  logic [SHIFT_W-1:0] sh;
  logic [PCT_W-1:0]   diff;
  logic [11:0]        acc;
  logic [11:0]        stepped;

  always_comb begin
    if (shift_i < 3'd1) begin
      sh = 3'd1;
    end else if (shift_i > 3'd4) begin
      sh = 3'd4;
    end else begin
      sh = shift_i;
    end
    diff = (target_i > filt_i) ? target_i - filt_i : filt_i - target_i;
    acc = ({5'b0, filt_i} << sh) - {5'b0, filt_i} + {5'b0, target_i}
        + (12'd1 << (sh - 3'd1));
    stepped = acc >> sh;
    if (!valid_i) begin
      result_o = '0;
    end else if (!primed_i) begin
      result_o = target_i;
    end else if (diff <= deadband_i) begin
      result_o = filt_i;
    end else begin
      result_o = stepped[PCT_W-1:0];
    end
  end

endmodule

// ----- sv/ppct_chk.sv -----
// port-level checker for the pedal percent normalizer, bound to the top level
module ppct_chk import ppct_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [SAMPLE_BITS-1:0] raw_sample_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [PCT_W-1:0]       percent_out_o,
  input logic                   signal_ok_o,
  input logic [SAMPLE_BITS-1:0] learned_min_o,
  input logic [SAMPLE_BITS-1:0] learned_max_o,
  input logic                   cfg_we_i,
  input logic [IDX_W-1:0]       cfg_idx_i,
  input logic [CFG_W-1:0]       cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(percent_out_o))
    else $error("result changed while stalled");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> percent_out_o <= 7'd100)
    else $error("percent above 100");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !signal_ok_o |-> percent_out_o == '0)
    else $error("nonzero percent on invalid signal");

  a_ok_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && signal_ok_o |-> learned_max_o > learned_min_o)
    else $error("signal ok with empty span");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while busy");

endmodule

bind pedal_self_calibrating_percent ppct_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_ppct_chk (.*);

// ----- dv/ppct_checker.sv -----
// checker for the pedal percent normalizer: predicts each result and compares it
module ppct_checker import ppct_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [SAMPLE_BITS-1:0] raw_sample_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [PCT_W-1:0]       percent_i,
  input  logic                   signal_ok_i,
  input  logic [SAMPLE_BITS-1:0] learned_min_i,
  input  logic [SAMPLE_BITS-1:0] learned_max_i,
  input  logic                   cfg_we_i,
  input  logic [IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  output int unsigned            err_cnt_o,
  output int unsigned            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SAMPLE_BITS-1:0] RAW_ALL_ONES = '1;

  typedef struct packed {
    logic [PCT_W-1:0]       pct;
    logic                   ok;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
  } pedal_res_t;

  logic [CFG_W-1:0]       span_thr;
  logic [CFG_W-1:0]       idle_win;
  logic [PCT_W-1:0]       deadband;
  logic [SHIFT_W-1:0]     flt_shift;
  logic [SAMPLE_BITS-1:0] min_seen;
  logic [SAMPLE_BITS-1:0] max_seen;
  logic [PCT_W-1:0]       flt_pct;
  logic                   primed;
  pedal_res_t             expected_pedal_q [$];
  int unsigned            n_bad = 0;
  int unsigned            n_seen = 0;

  assign err_cnt_o = n_bad;

  function automatic pedal_res_t predict_percent(input logic [SAMPLE_BITS-1:0] raw);
    int unsigned span;
    int unsigned tgt;
    int unsigned gap;
    int unsigned sh;
    int unsigned acc;
    logic        ok;
    pedal_res_t  r;
    if (raw < min_seen) min_seen = raw;
    if (raw > max_seen) max_seen = raw;
    tgt = 0;
    ok = 1'b0;
    if (max_seen > min_seen) begin
      span = 32'(max_seen) - 32'(min_seen);
      if (span >= 32'(span_thr)) begin
        ok = 1'b1;
        // idle window sum taken at full precision
        if (32'(raw) > 32'(min_seen) + 32'(idle_win)) begin
          tgt = ((32'(raw) - 32'(min_seen)) * 100) / span;
          if (tgt > 100) tgt = 100;
        end
      end
    end
    if (!ok) begin
      primed = 1'b0;
      flt_pct = '0;
    end else if (!primed) begin
      primed = 1'b1;
      flt_pct = PCT_W'(tgt);
    end else begin
      gap = (tgt > 32'(flt_pct)) ? tgt - 32'(flt_pct) : 32'(flt_pct) - tgt;
      if (gap > 32'(deadband)) begin
        sh = (flt_shift < 1) ? 1 : ((flt_shift > 4) ? 4 : 32'(flt_shift));
        acc = 32'(flt_pct) * ((1 << sh) - 1) + tgt + (1 << (sh - 1));
        flt_pct = PCT_W'(acc >> sh);
      end
    end
    r.pct = flt_pct;
    r.ok = ok;
    r.lo = min_seen;
    r.hi = max_seen;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pedal_res_t want;
    if (!rst_ni) begin
      span_thr = SPAN_THR_RST;
      idle_win = IDLE_WIN_RST;
      deadband = DEADBAND_RST;
      flt_shift = FLT_SHIFT_RST;
      min_seen = RAW_ALL_ONES;
      max_seen = '0;
      flt_pct = '0;
      primed = 1'b0;
      expected_pedal_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SPAN_THR:  span_thr = cfg_data_i;
          REG_IDLE_WIN:  idle_win = cfg_data_i;
          REG_DEADBAND:  deadband = cfg_data_i[PCT_W-1:0];
          REG_FLT_SHIFT: flt_shift = cfg_data_i[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        n_seen++;
        if (expected_pedal_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("[%0t] result %0d with nothing pending: pct %0d ok %0b min %0d max %0d",
                     $time, n_seen, percent_i, signal_ok_i, learned_min_i, learned_max_i);
        end else begin
          want = expected_pedal_q.pop_front();
          if (percent_i !== want.pct || signal_ok_i !== want.ok ||
              learned_min_i !== want.lo || learned_max_i !== want.hi) begin
            n_bad++;
            if (n_bad <= 10)
              $display("[%0t] result %0d: pct exp %0d got %0d, ok exp %0b got %0b, %s%0d %0d %s%0d %0d",
                       $time, n_seen, want.pct, percent_i, want.ok, signal_ok_i,
                       "min exp/got ", want.lo, learned_min_i,
                       "max exp/got ", want.hi, learned_max_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_pedal_q.push_back(predict_percent(raw_sample_i));
      pending_o <= expected_pedal_q.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// testbench top: drives pedal samples and register writes, reports the verdict
module tb import ppct_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned RAW_MAX = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned RAW_MID = 1 << (SAMPLE_BITS - 1);
  localparam int unsigned PCT_MAX = (1 << PCT_W) - 1;
  localparam int unsigned SHIFT_MAX = (1 << SHIFT_W) - 1;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 32;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_AT = 200;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned QUIET_LIMIT = 2000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [SAMPLE_BITS-1:0] raw_sample_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [PCT_W-1:0]       percent_out_o;
  logic                   signal_ok_o;
  logic [SAMPLE_BITS-1:0] learned_min_o;
  logic [SAMPLE_BITS-1:0] learned_max_o;
  logic                   cfg_we_i = 1'b0;
  logic [IDX_W-1:0]       cfg_idx_i = REG_SPAN_THR;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  int unsigned            chk_errs;
  int unsigned            chk_pending;
  bit                     tx_burst = 1'b0;
  bit                     rx_burst = 1'b0;

  // empty span, short span, threshold edge, idle window edge, deadband hold, new extremes
  int unsigned warmup [16] = '{2048, 2048, 2058, 2068, 2050, 2056, 2057, 2057,
                               2058, 2060, 2038, 2078, 2045, 2046, 2100, 2070};

  always #5 clk_i = ~clk_i;

  pedal_self_calibrating_percent #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_sample_i (raw_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .percent_out_o(percent_out_o),
    .signal_ok_o  (signal_ok_o),
    .learned_min_o(learned_min_o),
    .learned_max_o(learned_max_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  ppct_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .raw_sample_i (raw_sample_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .percent_i    (percent_out_o),
    .signal_ok_i  (signal_ok_o),
    .learned_min_i(learned_min_o),
    .learned_max_i(learned_max_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .err_cnt_o    (chk_errs),
    .pending_o    (chk_pending)
  );

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_sample_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned p;
    int unsigned thr;
    int unsigned idle;
    int unsigned db;
    int unsigned sh;
    int unsigned hw;
    int unsigned lo;
    int unsigned hi;
    int          s;
    int          prev;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (warmup[k]) send_sample(SAMPLE_BITS'(warmup[k]));
    prev = RAW_MID;
    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      // sample window widens phase by phase so the learned span grows slowly
      hw = (p < 8) ? (16 << p) : RAW_MID;
      lo = RAW_MID - hw;
      hi = RAW_MID + hw - 1;
      case (p)
        0: begin
          thr = RAW_MAX; idle = 0; db = 0; sh = 0;
        end
        1: begin
          thr = 0; idle = RAW_MAX; db = PCT_MAX; sh = SHIFT_MAX;
        end
        2: begin
          thr = 1; idle = 0; db = 100; sh = 4;
        end
        PHASES - 1: begin
          thr = RAW_MAX; idle = $urandom_range(0, 64); db = $urandom_range(0, 5); sh = 1;
        end
        default: begin
          thr = $urandom_range(1, (3 * hw > RAW_MAX) ? RAW_MAX : 3 * hw);
          idle = ($urandom_range(0, 3) == 0) ? $urandom_range(0, RAW_MAX)
                                             : $urandom_range(0, hw / 2);
          db = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PCT_MAX)
                                           : $urandom_range(0, 10);
          sh = $urandom_range(0, SHIFT_MAX);
        end
      endcase
      write_reg(REG_SPAN_THR, CFG_W'(thr));
      write_reg(REG_IDLE_WIN, CFG_W'(idle));
      write_reg(REG_DEADBAND, {(CFG_W-PCT_W)'($urandom), PCT_W'(db)});
      write_reg(REG_FLT_SHIFT, {(CFG_W-SHIFT_W)'($urandom), SHIFT_W'(sh)});
      cfg_we_i <= 1'b0;
      tx_burst = (p % 4 == 1);
      rx_burst = (p % 3 == 2);
      repeat (PHASE_ITEMS) begin
        // mostly a slow pedal walk, the rest jumps anywhere in the window
        if ($urandom_range(0, 9) < 6) begin
          s = prev + int'($urandom_range(0, 16)) - 8;
          if (s < int'(lo)) s = lo;
          if (s > int'(hi)) s = hi;
        end else begin
          s = $urandom_range(lo, hi);
        end
        if (p >= 8 && $urandom_range(0, 9) == 0) s = $urandom_range(0, 1) ? RAW_MAX : 0;
        prev = s;
        send_sample(SAMPLE_BITS'(s));
      end
    end
    wait_drained();
    if (chk_errs == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    int unsigned n_rx;
    n_rx = 0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      n_rx++;
      // long hold so the output register and core fill and the input stalls
      if (n_rx == HOLD_AT) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
